FILE: rtl/pfc_pkg.sv
// Shared types, format codes and register indexes for the pixel format converter.
package pfc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_FMT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COPY_RAW = 2'd2;

  typedef enum logic [2:0] {
    SRC_ARGB8    = 3'd0,
    SRC_RGB8     = 3'd1,
    SRC_RGB565   = 3'd2,
    SRC_ARGB1555 = 3'd3,
    SRC_ARGB4    = 3'd4,
    SRC_L8       = 3'd5,
    SRC_ARGB2    = 3'd6,
    SRC_PAL      = 3'd7
  } src_fmt_t;

  typedef enum logic [3:0] {
    TGT_ARGB8888  = 4'd0,
    TGT_PREMUL    = 4'd1,
    TGT_XRGB      = 4'd2,
    TGT_RGB888    = 4'd3,
    TGT_RGB565    = 4'd4,
    TGT_ARGB1555  = 4'd5,
    TGT_ARGB4444  = 4'd6,
    TGT_L8        = 4'd7,
    TGT_A8        = 4'd8,
    TGT_RGB565_SW = 4'd9,
    TGT_RGB565A8  = 4'd10,
    TGT_I1        = 4'd11,
    TGT_I2        = 4'd12,
    TGT_I4        = 4'd13,
    TGT_I8        = 4'd14,
    TGT_OTHER     = 4'd15
  } tgt_fmt_t;

  typedef struct packed {
    src_fmt_t src;
    tgt_fmt_t tgt;
    logic     copy_raw;
  } cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  bytes;
    logic [7:0]  alpha_byte;
    logic        alpha_valid;
    logic        row_end;
    logic        error;
  } res_t;

endpackage

FILE: rtl/pfc_convert.sv
// Color path: expand the source pixel to ARGB8 and pack it to the target format, or repack the raw pixel.
module pfc_convert (
  input  pfc_pkg::cfg_t       cfg,
  input  logic [31:0]         pixel,
  input  logic                row_last,
  output pfc_pkg::res_t       res
);

  function automatic logic [7:0] rep5(input logic [4:0] v);
    rep5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] rep6(input logic [5:0] v);
    rep6 = {v, v[5:4]};
  endfunction

  function automatic logic [7:0] rep4(input logic [3:0] v);
    rep4 = {v, v};
  endfunction

  function automatic logic [15:0] to565(input logic [31:0] c);
    to565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

  logic [7:0]  a, r, g, b;
  logic [31:0] argb;

  always_comb begin
    a = 8'hFF;
    r = 8'h00;
    g = 8'h00;
    b = 8'h00;
    case (cfg.src)
      pfc_pkg::SRC_ARGB8: begin
        a = pixel[31:24];
        r = pixel[23:16];
        g = pixel[15:8];
        b = pixel[7:0];
      end
      pfc_pkg::SRC_RGB8: begin
        r = pixel[23:16];
        g = pixel[15:8];
        b = pixel[7:0];
      end
      pfc_pkg::SRC_RGB565: begin
        r = rep5(pixel[15:11]);
        g = rep6(pixel[10:5]);
        b = rep5(pixel[4:0]);
      end
      pfc_pkg::SRC_ARGB1555: begin
        a = {8{pixel[15]}};
        r = rep5(pixel[14:10]);
        g = rep5(pixel[9:5]);
        b = rep5(pixel[4:0]);
      end
      pfc_pkg::SRC_ARGB4: begin
        a = rep4(pixel[15:12]);
        r = rep4(pixel[11:8]);
        g = rep4(pixel[7:4]);
        b = rep4(pixel[3:0]);
      end
      pfc_pkg::SRC_L8: begin
        r = pixel[7:0];
        g = pixel[7:0];
        b = pixel[7:0];
      end
      // two-bit fields times 85 is the field repeated four times
      pfc_pkg::SRC_ARGB2: begin
        a = {4{pixel[7:6]}};
        r = {4{pixel[5:4]}};
        g = {4{pixel[3:2]}};
        b = {4{pixel[1:0]}};
      end
      default: ; // paletted index shows as opaque black
    endcase
    argb = {a, r, g, b};
  end

  always_comb begin
    res             = '0;
    res.row_end     = row_last;
    res.word        = argb;
    res.bytes       = 3'd4;
    case (cfg.tgt) inside
      pfc_pkg::TGT_RGB565_SW: begin
        res.word  = {16'h0000, pixel[7:0], pixel[15:8]};
        res.bytes = 3'd2;
      end
      pfc_pkg::TGT_XRGB: begin
        res.word  = {8'hFF, pixel[23:0]};
        res.bytes = 3'd4;
      end
      pfc_pkg::TGT_RGB565A8: begin
        res.word        = {16'h0000, to565(pixel)};
        res.bytes       = 3'd2;
        res.alpha_byte  = pixel[31:24];
        res.alpha_valid = 1'b1;
      end
      default: begin
        if (cfg.copy_raw) begin
          case (cfg.tgt) inside
            pfc_pkg::TGT_RGB888: begin
              res.word  = {8'h00, pixel[23:0]};
              res.bytes = 3'd3;
            end
            pfc_pkg::TGT_RGB565, pfc_pkg::TGT_ARGB1555, pfc_pkg::TGT_ARGB4444: begin
              res.word  = {16'h0000, pixel[15:0]};
              res.bytes = 3'd2;
            end
            pfc_pkg::TGT_L8, pfc_pkg::TGT_A8: begin
              res.word  = {24'h000000, pixel[7:0]};
              res.bytes = 3'd1;
            end
            default: begin
              res.word  = pixel;
              res.bytes = 3'd4;
            end
          endcase
        end else begin
          case (cfg.tgt) inside
            pfc_pkg::TGT_RGB888: begin
              res.word  = {8'h00, argb[23:0]};
              res.bytes = 3'd3;
            end
            pfc_pkg::TGT_RGB565: begin
              res.word  = {16'h0000, to565(argb)};
              res.bytes = 3'd2;
            end
            pfc_pkg::TGT_ARGB1555: begin
              res.word  = {16'h0000, a[7], r[7:3], g[7:3], b[7:3]};
              res.bytes = 3'd2;
            end
            pfc_pkg::TGT_ARGB4444: begin
              res.word  = {16'h0000, a[7:4], r[7:4], g[7:4], b[7:4]};
              res.bytes = 3'd2;
            end
            // both luminance and alpha targets carry the alpha byte
            pfc_pkg::TGT_L8, pfc_pkg::TGT_A8: begin
              res.word  = {24'h000000, a};
              res.bytes = 3'd1;
            end
            default: begin
              res.word  = argb;
              res.bytes = 3'd4;
            end
          endcase
        end
      end
    endcase
  end

endmodule

FILE: rtl/pfc_index_pack.sv
// Index path: pack sub-byte indices MSB-first, pass I8 through, flag non-paletted sources.
module pfc_index_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  pfc_pkg::cfg_t       cfg,
  input  logic                clr,
  input  logic                adv,
  input  logic [31:0]         pixel,
  input  logic                row_last,
  output pfc_pkg::res_t       res,
  output logic                emit
);

  logic [7:0] pack_byte_r, pack_byte_nxt;
  logic [2:0] pack_cnt_r, pack_cnt_nxt;
  logic [3:0] ppb;
  logic [2:0] cnt_eff;
  logic [7:0] base;
  logic [7:0] merged;
  logic [3:0] cnt_inc;

  always_comb begin
    case (cfg.tgt)
      pfc_pkg::TGT_I1: ppb = 4'd8;
      pfc_pkg::TGT_I2: ppb = 4'd4;
      default:         ppb = 4'd2;
    endcase
    // a count already at a full byte starts a fresh byte
    if ({1'b0, pack_cnt_r} >= ppb) begin
      cnt_eff = 3'd0;
      base    = 8'h00;
    end else begin
      cnt_eff = pack_cnt_r;
      base    = pack_byte_r;
    end
    case (cfg.tgt)
      pfc_pkg::TGT_I1: merged = base | ({7'b0, pixel[0]} << (3'd7 - cnt_eff));
      pfc_pkg::TGT_I2: merged = base | ({6'b0, pixel[1:0]} << {2'd3 - cnt_eff[1:0], 1'b0});
      default:         merged = base | ({4'b0, pixel[3:0]} << {1'b1 - cnt_eff[0], 2'b00});
    endcase
    cnt_inc = {1'b0, cnt_eff} + 4'd1;
  end

  always_comb begin
    res           = '0;
    res.bytes     = 3'd1;
    res.row_end   = row_last;
    emit          = 1'b1;
    pack_byte_nxt = pack_byte_r;
    pack_cnt_nxt  = pack_cnt_r;
    if (cfg.src != pfc_pkg::SRC_PAL) begin
      res.error     = 1'b1;
      pack_byte_nxt = 8'h00;
      pack_cnt_nxt  = 3'd0;
    end else if (cfg.tgt == pfc_pkg::TGT_I8) begin
      res.word = {24'h000000, pixel[7:0]};
    end else begin
      res.word = {24'h000000, merged};
      if (cnt_inc == ppb || row_last) begin
        pack_byte_nxt = 8'h00;
        pack_cnt_nxt  = 3'd0;
      end else begin
        emit          = 1'b0;
        pack_byte_nxt = merged;
        pack_cnt_nxt  = cnt_inc[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      pack_byte_r <= 8'h00;
      pack_cnt_r  <= 3'd0;
    end else if (adv) begin
      pack_byte_r <= pack_byte_nxt;
      pack_cnt_r  <= pack_cnt_nxt;
    end
  end

endmodule

FILE: rtl/pixel_format_converter_top.sv
// Top level of the pixel format converter: config registers, input and result registers.
//
// Converts one source pixel per word on the in_ stream to the configured target format
// on the out_ stream. Configuration goes through cfg_we / cfg_index / cfg_wdata:
// index 0 source format, 1 target format, 2 raw copy. Write it only while the stream
// is idle; every write to a defined index clears the partial index byte.
// Each input word gives at most one output word. Sub-byte indexed targets (I1, I2, I4)
// with a paletted source emit a word only when a byte is full or at the last pixel of a
// row (in_tlast); every other case emits one word per input word.
// An accepted word lands in the input register and moves to the result register once
// that register is free; out_tvalid rises when the result register is loaded with it.
// Throughput: one word per cycle while the receiver does not stall, set by the single
// conversion stage between the input and result registers.
// When the receiver stalls, the result register holds its word and the input register
// holds one more; in_tready drops once both are full.
// Reset (rst_n low, synchronous) clears the configuration, the packing state and both
// valid flags.
module pixel_format_converter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pfc_pkg::PIX_W-1:0]           in_tdata,  // [31:0] pixel
  input  logic                                in_tlast,  // row_last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] out_word, [34:32] out_bytes, [42:35] alpha_byte, [43] alpha_valid,
  // [44] error, [47:45] zero
  output logic [pfc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast  // row_end
);

  pfc_pkg::cfg_t cfg_r;
  logic          cfg_clr;

  logic          s1_valid_r;
  logic [31:0]   s1_pixel_r;
  logic          s1_last_r;

  logic          out_valid_r;
  pfc_pkg::res_t out_res_r;

  logic          out_free;
  logic          s1_adv;
  logic          in_acc;
  logic          is_index;
  logic          emit;
  pfc_pkg::res_t cv_res;
  pfc_pkg::res_t ix_res;
  pfc_pkg::res_t sel_res;
  logic          ix_emit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src      <= pfc_pkg::SRC_ARGB8;
      cfg_r.tgt      <= pfc_pkg::TGT_ARGB8888;
      cfg_r.copy_raw <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfc_pkg::REG_SRC_FMT:  cfg_r.src      <= pfc_pkg::src_fmt_t'(cfg_wdata[2:0]);
        pfc_pkg::REG_TGT_FMT:  cfg_r.tgt      <= pfc_pkg::tgt_fmt_t'(cfg_wdata[3:0]);
        pfc_pkg::REG_COPY_RAW: cfg_r.copy_raw <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_clr = cfg_we && (cfg_index == pfc_pkg::REG_SRC_FMT ||
                              cfg_index == pfc_pkg::REG_TGT_FMT ||
                              cfg_index == pfc_pkg::REG_COPY_RAW);

  // Handshake: the input register advances whenever the result register can take a word
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_tdata;
      s1_last_r  <= in_tlast;
    end
  end

  assign is_index = (cfg_r.tgt == pfc_pkg::TGT_I1) || (cfg_r.tgt == pfc_pkg::TGT_I2) ||
                    (cfg_r.tgt == pfc_pkg::TGT_I4) || (cfg_r.tgt == pfc_pkg::TGT_I8);

  pfc_convert u_convert (
    .cfg      (cfg_r),
    .pixel    (s1_pixel_r),
    .row_last (s1_last_r),
    .res      (cv_res)
  );

  pfc_index_pack u_index_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .clr      (cfg_clr),
    .adv      (s1_adv && is_index),
    .pixel    (s1_pixel_r),
    .row_last (s1_last_r),
    .res      (ix_res),
    .emit     (ix_emit)
  );

  assign sel_res = is_index ? ix_res : cv_res;
  assign emit    = is_index ? ix_emit : 1'b1;

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_res_r <= sel_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.row_end;
  assign out_tdata  = {3'b000, out_res_r.error, out_res_r.alpha_valid, out_res_r.alpha_byte,
                       out_res_r.bytes, out_res_r.word};

endmodule

FILE: rtl/pfc_checker.sv
// Port-level checks for the pixel format converter, bound to the top level.
module pfc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pfc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:32] == 3'd1 || out_tdata[34:32] == 3'd2 ||
                    out_tdata[34:32] == 3'd3 || out_tdata[34:32] == 3'd4))
    else $error("byte count out of range");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44] |-> out_tdata[31:0] == 32'h0 && out_tdata[34:32] == 3'd1 &&
                                    !out_tdata[43] && out_tdata[42:35] == 8'h00)
    else $error("error word carries data");

  a_alpha_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[43] |-> out_tdata[34:32] == 3'd2 && out_tdata[31:16] == 16'h0)
    else $error("alpha plane byte without RGB565 word");

endmodule

bind pixel_format_converter_top pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: test/pixel_conv_checker.sv
// Checker for the pixel format converter: predicts each output word and compares it.
module pixel_conv_checker
  import pfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic [7:0]  alpha;
    logic        alpha_ok;
    logic        row_end;
    logic        err;
  } conv_word_t;

  src_fmt_t    src_q;
  tgt_fmt_t    tgt_q;
  logic        raw_q;
  logic [7:0]  idx_byte;
  int unsigned idx_count;

  conv_word_t  expected_words[$];

  function automatic logic [7:0] rep5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] rep6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] rep4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [15:0] to565(input logic [31:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

  // Widen the source pixel to A,R,G,B bytes
  function automatic logic [31:0] expand(input logic [31:0] pix);
    case (src_q)
      SRC_ARGB8:    return pix;
      SRC_RGB8:     return {8'hFF, pix[23:0]};
      SRC_RGB565:   return {8'hFF, rep5(pix[15:11]), rep6(pix[10:5]), rep5(pix[4:0])};
      SRC_ARGB1555: return {{8{pix[15]}}, rep5(pix[14:10]), rep5(pix[9:5]), rep5(pix[4:0])};
      SRC_ARGB4:    return {rep4(pix[15:12]), rep4(pix[11:8]), rep4(pix[7:4]), rep4(pix[3:0])};
      SRC_L8:       return {8'hFF, pix[7:0], pix[7:0], pix[7:0]};
      // 2-bit times 85 is the 2-bit value repeated four times
      SRC_ARGB2:    return {{4{pix[7:6]}}, {4{pix[5:4]}}, {4{pix[3:2]}}, {4{pix[1:0]}}};
      default:      return 32'hFF00_0000;
    endcase
  endfunction

  task automatic convert_pixel(input logic [31:0] pix, input logic last,
                               output logic emits, output conv_word_t res);
    logic [31:0] argb;
    int unsigned bpp;
    int unsigned per_byte;
    int unsigned shift;
    res = '0;
    res.row_end = last;
    emits = 1'b1;
    case (tgt_q)
      TGT_RGB565_SW: begin
        res.word = {16'h0, pix[7:0], pix[15:8]};
        res.nbytes = 3'd2;
      end
      TGT_XRGB: begin
        res.word = {8'hFF, pix[23:0]};
        res.nbytes = 3'd4;
      end
      TGT_RGB565A8: begin
        res.word = {16'h0, to565(pix)};
        res.nbytes = 3'd2;
        res.alpha = pix[31:24];
        res.alpha_ok = 1'b1;
      end
      TGT_I1, TGT_I2, TGT_I4, TGT_I8: begin
        res.nbytes = 3'd1;
        if (src_q != SRC_PAL) begin
          idx_byte = '0;
          idx_count = 0;
          res.err = 1'b1;
        end else if (tgt_q == TGT_I8) begin
          res.word = {24'h0, pix[7:0]};
        end else begin
          bpp = 1 << (int'(tgt_q) - int'(TGT_I1));
          per_byte = 8 / bpp;
          if (idx_count >= per_byte) begin
            idx_byte = '0;
            idx_count = 0;
          end
          // first index lands in the top bits
          shift = (per_byte - 1 - idx_count) * bpp;
          idx_byte = idx_byte | 8'((pix & ((32'd1 << bpp) - 32'd1)) << shift);
          idx_count++;
          if (idx_count == per_byte || last) begin
            res.word = {24'h0, idx_byte};
            idx_byte = '0;
            idx_count = 0;
          end else begin
            emits = 1'b0;
          end
        end
      end
      default: begin
        if (raw_q) begin
          case (tgt_q)
            TGT_RGB888: begin
              res.word = {8'h0, pix[23:0]};
              res.nbytes = 3'd3;
            end
            TGT_RGB565, TGT_ARGB1555, TGT_ARGB4444: begin
              res.word = {16'h0, pix[15:0]};
              res.nbytes = 3'd2;
            end
            TGT_L8, TGT_A8: begin
              res.word = {24'h0, pix[7:0]};
              res.nbytes = 3'd1;
            end
            default: begin
              res.word = pix;
              res.nbytes = 3'd4;
            end
          endcase
        end else begin
          argb = expand(pix);
          case (tgt_q)
            TGT_RGB888: begin
              res.word = {8'h0, argb[23:0]};
              res.nbytes = 3'd3;
            end
            TGT_RGB565: begin
              res.word = {16'h0, to565(argb)};
              res.nbytes = 3'd2;
            end
            TGT_ARGB1555: begin
              res.word = {16'h0, argb[31], argb[23:19], argb[15:11], argb[7:3]};
              res.nbytes = 3'd2;
            end
            TGT_ARGB4444: begin
              res.word = {16'h0, argb[31:28], argb[23:20], argb[15:12], argb[7:4]};
              res.nbytes = 3'd2;
            end
            // both single-byte targets carry alpha
            TGT_L8, TGT_A8: begin
              res.word = {24'h0, argb[31:24]};
              res.nbytes = 3'd1;
            end
            default: begin
              res.word = argb;
              res.nbytes = 3'd4;
            end
          endcase
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    conv_word_t want;
    conv_word_t got;
    logic       emits;
    if (!rst_n) begin
      src_q = SRC_ARGB8;
      tgt_q = TGT_ARGB8888;
      raw_q = 1'b0;
      idx_byte = '0;
      idx_count = 0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_FMT: src_q = src_fmt_t'(cfg_wdata[2:0]);
          REG_TGT_FMT: tgt_q = tgt_fmt_t'(cfg_wdata[3:0]);
          REG_COPY_RAW: raw_q = cfg_wdata[0];
          default: ;
        endcase
        // any defined register drops the partial index byte
        if (cfg_index == REG_SRC_FMT || cfg_index == REG_TGT_FMT ||
            cfg_index == REG_COPY_RAW) begin
          idx_byte = '0;
          idx_count = 0;
        end
      end
      if (in_tvalid && in_tready) begin
        convert_pixel(in_tdata, in_tlast, emits, want);
        if (emits) expected_words.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.word     = out_tdata[31:0];
        got.nbytes   = out_tdata[34:32];
        got.alpha    = out_tdata[42:35];
        got.alpha_ok = out_tdata[43];
        got.err      = out_tdata[44];
        got.row_end  = out_tlast;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word=%h bytes=%0d alpha=%h av=%b last=%b err=%b",
                   $time, got.word, got.nbytes, got.alpha, got.alpha_ok, got.row_end,
                   got.err);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: expected word=%h bytes=%0d alpha=%h av=%b last=%b err=%b",
                     $time, want.word, want.nbytes, want.alpha, want.alpha_ok,
                     want.row_end, want.err);
            $display("%0t:   actual word=%h bytes=%0d alpha=%h av=%b last=%b err=%b",
                     $time, got.word, got.nbytes, got.alpha, got.alpha_ok, got.row_end,
                     got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

FILE: test/testbench.sv
// Testbench top for the pixel format converter: clock, reset, stimulus and verdict.
module testbench;
  import pfc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int fail_count;
  int pending;
  int send_idle  = 0;
  int recv_stall = 0;

  pixel_format_converter_top dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  pixel_conv_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  initial begin
    #2000000;
    $display("[pixel_format_converter_top] ERROR");
    $finish;
  end

  // Write all three registers; upper data bits of the source and raw-copy writes carry noise the block must mask
  task automatic set_config(input src_fmt_t s, input tgt_fmt_t t, input logic raw);
    cfg_we <= 1'b1;
    cfg_index <= REG_SRC_FMT;
    cfg_wdata <= {1'($urandom), s};
    @(posedge clk);
    cfg_index <= REG_TGT_FMT;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_index <= REG_COPY_RAW;
    cfg_wdata <= {3'($urandom), raw};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input logic [31:0] pix, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the sender until every expected word is out, then let the pipe settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_block(input int n_items);
    src_fmt_t    s;
    tgt_fmt_t    t;
    logic        raw;
    int          left;
    int          run;
    logic [31:0] pix;
    t = tgt_fmt_t'($urandom_range(0, 15));
    // indexed targets mostly get a paletted source so packing is reached
    if (t >= TGT_I1 && t <= TGT_I8 && $urandom_range(0, 9) < 8) s = SRC_PAL;
    else s = src_fmt_t'($urandom_range(0, 7));
    raw = 1'($urandom_range(0, 1));
    set_config(s, t, raw);
    left = n_items;
    while (left > 0) begin
      run = $urandom_range(1, 12);
      if (run > left) run = left;
      for (int i = 0; i < run; i++) begin
        case ($urandom_range(0, 15))
          0:       pix = 32'h0000_0000;
          1:       pix = 32'hFFFF_FFFF;
          default: pix = $urandom;
        endcase
        send_word(pix, (i == run - 1) ? 1'b1 : ($urandom_range(0, 19) == 0));
      end
      left -= run;
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(SRC_ARGB8, TGT_ARGB8888, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    wait_drained();
    set_config(SRC_RGB8, TGT_PREMUL, 1'b0);
    send_word(32'h8012_3456, 1'b1);
    wait_drained();
    set_config(SRC_RGB565, TGT_ARGB1555, 1'b0);
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'hFFFF_0821, 1'b1);
    wait_drained();
    set_config(SRC_ARGB1555, TGT_ARGB4444, 1'b0);
    send_word(32'h0000_8000, 1'b0);
    send_word(32'h0000_7FFF, 1'b1);
    wait_drained();
    set_config(SRC_ARGB4, TGT_RGB565, 1'b0);
    send_word(32'h0000_F0F0, 1'b1);
    wait_drained();
    set_config(SRC_L8, TGT_L8, 1'b0);
    send_word(32'h0000_00AB, 1'b1);
    wait_drained();
    set_config(SRC_ARGB2, TGT_OTHER, 1'b0);
    send_word(32'h0000_00E4, 1'b1);
    wait_drained();
    // paletted source on a colour target comes out black
    set_config(SRC_PAL, TGT_RGB888, 1'b0);
    send_word(32'h1234_5678, 1'b1);
    wait_drained();
    set_config(SRC_ARGB8, TGT_RGB565, 1'b1);
    send_word(32'hDEAD_BEEF, 1'b1);
    wait_drained();
    set_config(SRC_RGB565, TGT_RGB565_SW, 1'b1);
    send_word(32'h1234_ABCD, 1'b1);
    wait_drained();
    set_config(SRC_ARGB4, TGT_XRGB, 1'b1);
    send_word(32'h00AB_CDEF, 1'b1);
    wait_drained();
    set_config(SRC_L8, TGT_RGB565A8, 1'b0);
    send_word(32'h80FF_00FF, 1'b1);
    wait_drained();
    // half a byte of 2-bit indices, a write to an unused index, then finish and flush
    set_config(SRC_PAL, TGT_I2, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0002, 1'b0);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0003, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    wait_drained();
    set_config(SRC_RGB8, TGT_I4, 1'b0);
    send_word(32'h0000_0005, 1'b1);
    wait_drained();
    set_config(SRC_PAL, TGT_I8, 1'b1);
    send_word(32'hFFFF_FF7F, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      repeat (6) random_block($urandom_range(30, 50));
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[pixel_format_converter_top] OK");
    end else begin
      $display("[pixel_format_converter_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pfc_pkg.sv
rtl/pfc_convert.sv
rtl/pfc_index_pack.sv
rtl/pixel_format_converter_top.sv
rtl/pfc_checker.sv
test/pixel_conv_checker.sv
test/testbench.sv
